FILE: src/sffm_pkg.sv
package sffm_pkg;

    // Default build parameters
    localparam int unsigned SINE_TABLE_BITS_DEF = 10;
    localparam int unsigned PHASE_BITS_DEF      = 32;

    // Queue depths (powers of two) and their occupancy widths
    localparam int unsigned MID_DEPTH = 4;
    localparam int unsigned OUT_DEPTH = 8;
    localparam int unsigned MID_CNT_W = $clog2(MID_DEPTH + 1);
    localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Configuration port
    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [2:0] REG_OFFSET           = 3'd0;
    localparam logic [2:0] REG_AMPLITUDE        = 3'd1;
    localparam logic [2:0] REG_CARRIER_STEP     = 3'd2;
    localparam logic [2:0] REG_SIGNAL_STEP      = 3'd3;
    localparam logic [2:0] REG_MODULATION_INDEX = 3'd4;

    // pi/2 in Q30 and 2^32/(2*pi)
    localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

    typedef struct packed {
        logic signed [15:0] offset;
        logic signed [15:0] amplitude;
        logic [31:0]        carrier_step;
        logic [31:0]        signal_step;
        logic [15:0]        modulation_index;
    } sffm_cfg_t;

    // Quarter-wave sine entry: round(32767 * sin(pi/2 * idx / 2^tbits)),
    // from a ten-term Taylor series in Q30. Evaluated at elaboration only.
    function automatic logic [14:0] sine_entry(input int unsigned idx,
                                               input int unsigned tbits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        x    = (HALF_PI_Q30 * 64'(idx)) >> tbits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd272;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd342;
        sum  = sum - $signed(term);
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        v = (64'(sum) * 64'd32767 + 64'd536870912) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[14:0];
    endfunction

endpackage

FILE: src/sffm_fifo.sv
module sffm_fifo
    import sffm_pkg::*;
#(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_pop;

    assign empty  = (count_reg == '0);
    assign count  = count_reg;
    assign rdata  = mem_reg[rd_ptr_reg];
    assign do_pop = pop & ~empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push);
        rd_ptr_next = rd_ptr_reg + PTR_W'(do_pop);
        count_next  = count_reg + CNT_W'(push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Writers hold credit, so a write never lands on a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != CNT_W'(DEPTH))
        else $error("sffm_fifo: write while full");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !do_pop) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("sffm_fifo: occupancy did not advance on write");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !push) |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("sffm_fifo: occupancy did not drop on read");

endmodule

FILE: src/sffm_front.sv
module sffm_front
    import sffm_pkg::*;
#(
    parameter int unsigned PHASE_BITS = PHASE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [31:0]           sample_index,
    input  sffm_cfg_t             cfg,
    input  logic [MID_CNT_W-1:0]  mid_count,
    output logic                  mid_push,
    output logic [PHASE_BITS-1:0] mid_carrier,
    output logic [PHASE_BITS-1:0] mid_signal
);

    localparam int unsigned OCC_W = MID_CNT_W + 1;

    logic                  accept;
    logic [OCC_W-1:0]      occupancy;
    logic                  v0_reg;
    logic                  v1_reg;
    logic [31:0]           n_reg;
    logic [31:0]           cph_raw;
    logic [31:0]           sph_raw;
    logic [PHASE_BITS-1:0] cph_reg;
    logic [PHASE_BITS-1:0] sph_reg;

    // Scale a 32-bit turn to PHASE_BITS: drop low bits or append zeros
    function automatic logic [PHASE_BITS-1:0] to_phase(input logic [31:0] p);
        logic [PHASE_BITS+31:0] wide;
        wide = {p, PHASE_BITS'(0)};
        return wide[PHASE_BITS+31 -: PHASE_BITS];
    endfunction

    // Count queued plus in-flight items against the queue depth
    assign occupancy = OCC_W'(mid_count) + OCC_W'(v0_reg) + OCC_W'(v1_reg);
    assign full      = (occupancy >= OCC_W'(MID_DEPTH));
    assign accept    = push & ~full;

    assign cph_raw = n_reg * cfg.carrier_step;
    assign sph_raw = n_reg * cfg.signal_step;

    assign mid_push    = v1_reg;
    assign mid_carrier = cph_reg;
    assign mid_signal  = sph_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= sample_index;
        cph_reg <= to_phase(cph_raw);
        sph_reg <= to_phase(sph_raw);
    end

endmodule

FILE: src/sffm_back.sv
module sffm_back
    import sffm_pkg::*;
#(
    parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int unsigned PHASE_BITS      = PHASE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sffm_cfg_t             cfg,
    input  logic                  mid_empty,
    input  logic [PHASE_BITS-1:0] mid_carrier,
    input  logic [PHASE_BITS-1:0] mid_signal,
    output logic                  mid_pop,
    input  logic [OUT_CNT_W-1:0]  out_count,
    output logic                  res_push,
    output logic [15:0]           res_value
);

    localparam int unsigned L        = 2 ** SINE_TABLE_BITS;
    localparam int unsigned AW       = SINE_TABLE_BITS + 1;
    localparam int unsigned SH       = 59 - PHASE_BITS;
    localparam int unsigned MAG_W    = 15;
    localparam int unsigned DMAG_W   = 31;
    localparam int unsigned DEVP_W   = 61;
    localparam int unsigned RND_W    = 62;
    localparam int unsigned BACK_LAT = 6;
    localparam int unsigned INF_W    = $clog2(BACK_LAT + 1);
    localparam int unsigned OCC_W    = OUT_CNT_W + 1;

    typedef logic [MAG_W-1:0] sffm_rom_t [0:L];

    function automatic sffm_rom_t build_rom();
        sffm_rom_t rom;
        for (int i = 0; i <= int'(L); i++)
        begin
            rom[i] = sine_entry(i, SINE_TABLE_BITS);
        end
        return rom;
    endfunction

    localparam sffm_rom_t SINE_ROM = build_rom();

    // Odd quadrants mirror the table
    function automatic logic [AW-1:0] rom_addr(input logic [PHASE_BITS-1:0] ph);
        logic [SINE_TABLE_BITS-1:0] k;
        k = ph[PHASE_BITS-3 -: SINE_TABLE_BITS];
        if (ph[PHASE_BITS-2])
        begin
            return AW'(L) - {1'b0, k};
        end
        return {1'b0, k};
    endfunction

    logic                  issue;
    logic [OCC_W-1:0]      occupancy;
    logic [BACK_LAT-1:0]   v_reg;
    logic [INF_W-1:0]      inflight_reg;
    logic [INF_W-1:0]      inflight_next;

    logic [MAG_W-1:0]      s_mag_reg;
    logic                  s_neg_reg;
    logic [PHASE_BITS-1:0] cph1_reg;
    logic [DMAG_W-1:0]     dmag_reg;
    logic                  dneg2_reg;
    logic [PHASE_BITS-1:0] cph2_reg;
    logic [DEVP_W-1:0]     devp_reg;
    logic                  dneg3_reg;
    logic [PHASE_BITS-1:0] cph3_reg;
    logic [RND_W-1:0]      dev_rnd;
    logic [PHASE_BITS-1:0] dev_reg;
    logic                  dneg4_reg;
    logic [PHASE_BITS-1:0] cph4_reg;
    logic [PHASE_BITS-1:0] total;
    logic [MAG_W-1:0]      c_mag_reg;
    logic                  c_neg_reg;
    logic signed [15:0]    sc;
    logic signed [31:0]    prod_reg;
    logic signed [31:0]    prod_rnd;
    logic signed [16:0]    scaled;
    logic signed [17:0]    sum;

    // Issue only with room reserved in the result queue
    assign occupancy = OCC_W'(out_count) + OCC_W'(inflight_reg);
    assign issue     = ~mid_empty && (occupancy < OCC_W'(OUT_DEPTH));
    assign mid_pop   = issue;
    assign res_push  = v_reg[BACK_LAT-1];

    assign inflight_next = inflight_reg + INF_W'(issue) - INF_W'(v_reg[BACK_LAT-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg        <= '0;
            inflight_reg <= '0;
        end
        else
        begin
            v_reg        <= {v_reg[BACK_LAT-2:0], issue};
            inflight_reg <= inflight_next;
        end
    end

    assign dev_rnd = RND_W'(devp_reg) + (RND_W'(1) << (SH - 1));
    assign total   = dneg4_reg ? (cph4_reg - dev_reg) : (cph4_reg + dev_reg);
    assign sc      = c_neg_reg ? -$signed({1'b0, c_mag_reg}) : $signed({1'b0, c_mag_reg});

    always_ff @(posedge clk)
    begin
        s_mag_reg <= SINE_ROM[rom_addr(mid_signal)];
        s_neg_reg <= mid_signal[PHASE_BITS-1];
        cph1_reg  <= mid_carrier;

        dmag_reg  <= DMAG_W'(cfg.modulation_index) * DMAG_W'(s_mag_reg);
        dneg2_reg <= s_neg_reg;
        cph2_reg  <= cph1_reg;

        devp_reg  <= DEVP_W'(dmag_reg) * DEVP_W'(INV_TWO_PI_Q32);
        dneg3_reg <= dneg2_reg;
        cph3_reg  <= cph2_reg;

        dev_reg   <= dev_rnd[SH +: PHASE_BITS];
        dneg4_reg <= dneg3_reg;
        cph4_reg  <= cph3_reg;

        c_mag_reg <= SINE_ROM[rom_addr(total)];
        c_neg_reg <= total[PHASE_BITS-1];

        prod_reg  <= 32'(cfg.amplitude) * 32'(sc);
    end

    // Round half up, add offset, clamp to 16 bits
    assign prod_rnd = prod_reg + 32'sd16384;
    assign scaled   = prod_rnd[31:15];
    assign sum      = {scaled[16], scaled} + {{2{cfg.offset[15]}}, cfg.offset};

    always_comb
    begin
        if (sum > 18'sd32767)
        begin
            res_value = 16'h7FFF;
        end
        else if (sum < -18'sd32768)
        begin
            res_value = 16'h8000;
        end
        else
        begin
            res_value = sum[15:0];
        end
    end

endmodule

FILE: src/single_frequency_fm_source_unit.sv
// Path: the front registers the sample index and both phases, the middle queue holds them,
//   and the back pipeline computes each result for the output queue.
// Throughput: one sample per clock unless full; the result queue decouples a stalled consumer.
// Reset: configuration returns to offset 0, amplitude 32767, steps and index 0; both
//   queues empty. The sine table is a constant ROM, so no clearing pass is needed.
module single_frequency_fm_source_unit
    import sffm_pkg::*;
#(
    parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int unsigned PHASE_BITS      = PHASE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Sample index input queue
    input  logic                  push,
    output logic                  full,
    input  logic [31:0]           sample_index,

    // Result queue
    output logic                  empty,
    input  logic                  pop,
    output logic signed [15:0]    value,

    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // ---------------------------------------------------------------------------------------
    // Configuration registers. The port never waits; a write transaction lands at the
    // access edge. Addresses past the last register drop the write and read back zero.
    // ---------------------------------------------------------------------------------------
    sffm_cfg_t  cfg_reg;
    sffm_cfg_t  cfg_next;
    logic       cfg_write;
    logic [2:0] cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_sel   = paddr[CFG_ADDR_W-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_sel)
                REG_OFFSET:           cfg_next.offset           = pwdata[15:0];
                REG_AMPLITUDE:        cfg_next.amplitude        = pwdata[15:0];
                REG_CARRIER_STEP:     cfg_next.carrier_step     = pwdata;
                REG_SIGNAL_STEP:      cfg_next.signal_step      = pwdata;
                REG_MODULATION_INDEX: cfg_next.modulation_index = pwdata[15:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_OFFSET:           prdata = {16'b0, cfg_reg.offset};
            REG_AMPLITUDE:        prdata = {16'b0, cfg_reg.amplitude};
            REG_CARRIER_STEP:     prdata = cfg_reg.carrier_step;
            REG_SIGNAL_STEP:      prdata = cfg_reg.signal_step;
            REG_MODULATION_INDEX: prdata = {16'b0, cfg_reg.modulation_index};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset           <= 16'sd0;
            cfg_reg.amplitude        <= 16'sd32767;
            cfg_reg.carrier_step     <= 32'd0;
            cfg_reg.signal_step      <= 32'd0;
            cfg_reg.modulation_index <= 16'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Front: register the sample index, then form both phases with two 32x32 multipliers
    // (kept modulo one turn) and scale them to PHASE_BITS. It raises full when the middle
    // queue has no slot left for the items it already holds in flight.
    // ---------------------------------------------------------------------------------------
    logic                  mid_push;
    logic                  mid_pop;
    logic                  mid_empty;
    logic [MID_CNT_W-1:0]  mid_count;
    logic [PHASE_BITS-1:0] front_carrier;
    logic [PHASE_BITS-1:0] front_signal;
    logic [PHASE_BITS-1:0] back_carrier;
    logic [PHASE_BITS-1:0] back_signal;

    sffm_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .sample_index (sample_index),
        .cfg          (cfg_reg),
        .mid_count    (mid_count),
        .mid_push     (mid_push),
        .mid_carrier  (front_carrier),
        .mid_signal   (front_signal)
    );

    // Middle queue: carrier and signal phase of each accepted sample
    sffm_fifo #(
        .WIDTH (2 * PHASE_BITS),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata ({front_carrier, front_signal}),
        .pop   (mid_pop),
        .rdata ({back_carrier, back_signal}),
        .empty (mid_empty),
        .count (mid_count)
    );

    // ---------------------------------------------------------------------------------------
    // Back: a six-stage pipeline that never stalls. It looks up sin(signal), scales it by
    // the modulation index and 2^32/(2*pi), adds the deviation to the carrier phase, looks
    // up the carrier sine in the same constant ROM, multiplies by the amplitude, then rounds,
    // adds the offset and saturates. It issues only while the result queue can absorb every
    // item in flight, so back-pressure from pop never reaches the pipeline registers.
    // ---------------------------------------------------------------------------------------
    logic                 res_push;
    logic [15:0]          res_value;
    logic [OUT_CNT_W-1:0] out_count;
    logic [15:0]          out_value;

    sffm_back #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .PHASE_BITS      (PHASE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .mid_empty   (mid_empty),
        .mid_carrier (back_carrier),
        .mid_signal  (back_signal),
        .mid_pop     (mid_pop),
        .out_count   (out_count),
        .res_push    (res_push),
        .res_value   (res_value)
    );

    // Result queue: hold each finished sample until the consumer takes the transaction
    sffm_fifo #(
        .WIDTH (16),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_value),
        .pop   (pop),
        .rdata (out_value),
        .empty (empty),
        .count (out_count)
    );

    assign value = $signed(out_value);

endmodule

FILE: tb/single_frequency_fm_source_unit_test.sv
`timescale 1ns / 100ps

module single_frequency_fm_source_unit_test;
    import sffm_pkg::*;

    // Build sizes of the instance; the predictor follows them.
    localparam int unsigned LUT_BITS = SINE_TABLE_BITS_DEF;
    localparam int unsigned PH_BITS  = PHASE_BITS_DEF;
    localparam int unsigned LUT_LEN  = 1 << LUT_BITS;
    localparam longint unsigned PHASE_MASK = (64'd1 << PH_BITS) - 64'd1;
    localparam int unsigned DEV_SHIFT = 59 - PH_BITS;

    // pi/2 in Q30 and one radian in phase units (2^32 / 2pi)
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam longint unsigned RAD_TO_PHASE     = 64'd683565276;

    // Register slots past the last real register; writes there must be dropped.
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam int unsigned TOTAL_SAMPLES  = 1350;
    localparam int unsigned LATENCY_WAIT   = 12;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MAX_REPORTS    = 50;

    typedef struct {
        logic [31:0]        sample_index;
        logic signed [15:0] value;
    } fm_expect_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [31:0]           sample_index = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic signed [15:0]    value;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    single_frequency_fm_source_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .sample_index (sample_index),
        .empty        (empty),
        .pop          (pop),
        .value        (value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #1 clk = ~clk;

    // Shadow of the register file, starting from the reset values.
    sffm_cfg_t fm_cfg = '{16'sd0, 16'sd32767, 32'd0, 32'd0, 16'd0};

    int         sine_lut [0:LUT_LEN];
    fm_expect_t pending_samples [$];
    fm_expect_t oldest;

    int unsigned samples_sent    = 0;
    int unsigned results_checked = 0;
    int unsigned settings_loaded = 0;
    int unsigned mismatch_count  = 0;
    int unsigned pop_stall       = 0;
    int unsigned stalled_cycles  = 0;
    bit          tx_idling       = 1'b0;
    bit          rx_idling       = 1'b0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One quarter-wave entry: Taylor series of sin in Q30, then scaled to 32767.
    function automatic int quarter_sine(int unsigned i);
        longint unsigned x, x2, term, v;
        longint          acc;
        x    = (QUARTER_TURN_Q30 * 64'(i)) / 64'(LUT_LEN);
        x2   = (x * x) >> 30;
        term = x;
        acc  = $signed(x);
        for (int n = 1; n <= 9; n++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc -= $signed(term);
            else
                acc += $signed(term);
        end
        if (acc < 0)
            acc = 0;
        v = ($unsigned(acc) * 64'd32767 + 64'd536870912) >> 30;
        if (v > 64'd32767)
            v = 64'd32767;
        return int'(v);
    endfunction

    // Scale a 32-bit phase to the internal phase width.
    function automatic longint unsigned widen_phase(logic [31:0] p);
        longint unsigned w;
        w = {32'd0, p};
        if (PH_BITS <= 32)
            w = w >> (32 - PH_BITS);
        else
            w = w << (PH_BITS - 32);
        return w & PHASE_MASK;
    endfunction

    // Quadrant from the top two bits, table index from the next ones; no interpolation.
    function automatic int sine_at(longint unsigned ph);
        longint unsigned top;
        int unsigned     k, q;
        int              s;
        top = (ph & PHASE_MASK) >> (PH_BITS - 2 - LUT_BITS);
        k   = int'(top % LUT_LEN);
        q   = int'((top / LUT_LEN) % 4);
        s   = (q % 2 == 1) ? sine_lut[LUT_LEN - k] : sine_lut[k];
        return (q >= 2) ? -s : s;
    endfunction

    function automatic logic signed [15:0] predict_fm_sample(logic [31:0] n);
        logic [31:0]     cph, sph;
        int              s_sig, s_car;
        longint          dev_raw, prod, sum;
        longint unsigned mag, dev, total;
        // Both phases wrap modulo 2^32 with the sample index.
        cph     = n * fm_cfg.carrier_step;
        sph     = n * fm_cfg.signal_step;
        s_sig   = sine_at(widen_phase(sph));
        dev_raw = longint'(fm_cfg.modulation_index) * longint'(s_sig);
        // Round the deviation magnitude half away from zero, then restore the sign.
        mag     = (dev_raw < 0) ? $unsigned(-dev_raw) : $unsigned(dev_raw);
        dev     = (mag * RAD_TO_PHASE + (64'd1 << (DEV_SHIFT - 1))) >> DEV_SHIFT;
        total   = widen_phase(cph);
        if (dev_raw < 0)
            total = (total - dev) & PHASE_MASK;
        else
            total = (total + dev) & PHASE_MASK;
        s_car = sine_at(total);
        // Q2.30 product down to Q1.15, ties toward plus infinity, then saturate.
        prod = longint'(fm_cfg.amplitude) * longint'(s_car);
        sum  = ((prod + 64'sd16384) >>> 15) + longint'(fm_cfg.offset);
        if (sum > 32767)
            sum = 32767;
        else if (sum < -32768)
            sum = -32768;
        return 16'(sum);
    endfunction

    function automatic void apply_reg_write(logic [2:0] idx, logic [31:0] data);
        // Bits above each register's width are dropped; unknown slots change nothing.
        case (idx)
            REG_OFFSET:           fm_cfg.offset           = data[15:0];
            REG_AMPLITUDE:        fm_cfg.amplitude        = data[15:0];
            REG_CARRIER_STEP:     fm_cfg.carrier_step     = data;
            REG_SIGNAL_STEP:      fm_cfg.signal_step      = data;
            REG_MODULATION_INDEX: fm_cfg.modulation_index = data[15:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Random picks
    // ------------------------------------------------------------------

    // Mostly short gaps, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_sample_index();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 4095);
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 4095);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(1, 1 << 20);
            3:       return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_q15();
        case ($urandom_range(0, 5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_mod_index();
        case ($urandom_range(0, 5))
            0:       return 16'hFFFF;
            1:       return 16'h0000;
            2:       return 16'($urandom_range(0, 4096));
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Setup phase, access phase, then a quiet phase with psel low so that back-to-back
    // writes never touch psel twice in one step.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_reg_write(idx, data);
        @(posedge clk);
    endtask

    // Write all five registers; junk goes into the unused upper bits.
    task automatic load_setting(input logic [15:0] off, input logic [15:0] amp,
                                input logic [31:0] cstep, input logic [31:0] sstep,
                                input logic [15:0] mod_index);
        write_reg(REG_OFFSET,           {16'($urandom), off});
        write_reg(REG_AMPLITUDE,        {16'($urandom), amp});
        write_reg(REG_CARRIER_STEP,     cstep);
        write_reg(REG_SIGNAL_STEP,      sstep);
        write_reg(REG_MODULATION_INDEX, {16'($urandom), mod_index});
        settings_loaded++;
    endtask

    // Offer one sample index and hold it until the block takes it.
    task automatic push_sample(input logic [31:0] n);
        fm_expect_t e;
        int unsigned gap;
        e.sample_index = n;
        e.value        = predict_fm_sample(n);
        if (tx_idling && $urandom_range(0, 3) == 0)
        begin
            gap = pick_gap();
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push         <= 1'b1;
        sample_index <= n;
        do @(posedge clk); while (full !== 1'b0);
        pending_samples.push_back(e);
        samples_sent++;
    endtask

    // Drop push, let every outstanding result come back, then let the pipe settle.
    task automatic wait_until_idle();
        push <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] n,
                                   input logic signed [15:0] want,
                                   input logic signed [15:0] got);
        mismatch_count++;
        // Keep the log readable when everything goes wrong at once.
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH %s: sample_index=0x%08h expected %0d got %0d",
                     what, n, want, got);
    endtask

    // ------------------------------------------------------------------
    // Result side: compare each popped transaction, then decide the next pop.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_samples.size() == 0)
                report_mismatch("result with nothing outstanding", 32'd0, 16'sd0, value);
            else
            begin
                oldest = pending_samples.pop_front();
                results_checked++;
                if (value !== oldest.value)
                    report_mismatch("value", oldest.sample_index, oldest.value, value);
            end
        end
        if (!rst_n)
            pop <= 1'b0;
        else if (pop_stall > 0)
        begin
            pop <= 1'b0;
            pop_stall--;
        end
        else
        begin
            pop <= 1'b1;
            if (rx_idling && $urandom_range(0, 3) == 0)
                pop_stall = pick_gap();
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                     stalled_cycles, pending_samples.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: zero steps hold both phases at zero, so the output is flat.
    task automatic test_reset_defaults();
        push_sample(32'd0);
        push_sample(32'hFFFF_FFFF);
        push_sample(32'h8000_0000);
        wait_until_idle();
    endtask

    task automatic test_directed_corners();
        // Quarter-turn carrier: walk the four quadrants; full-scale sine is 32767.
        // The all-ones index wraps the phase back to three quarters.
        load_setting(16'h0000, 16'h7FFF, 32'h4000_0000, 32'd0, 16'h0000);
        push_sample(32'd1);
        push_sample(32'd2);
        push_sample(32'd3);
        push_sample(32'hFFFF_FFFF);
        wait_until_idle();

        // Most negative amplitude with top offset, then the reverse, both ends of the sum saturating.
        load_setting(16'h7FFF, 16'h8000, 32'h4000_0000, 32'd0, 16'h0000);
        push_sample(32'd1);
        push_sample(32'd3);
        wait_until_idle();
        load_setting(16'h8000, 16'h7FFF, 32'h4000_0000, 32'd0, 16'h0000);
        push_sample(32'd1);
        push_sample(32'd3);
        wait_until_idle();

        // Largest modulation index: deviation of nearly 16 radians, both signs.
        load_setting(16'h0000, 16'h7FFF, 32'd0, 32'h4000_0000, 16'hFFFF);
        push_sample(32'd1);
        push_sample(32'd2);
        push_sample(32'd3);
        wait_until_idle();

        // Writes to empty register slots must leave the setting untouched.
        load_setting(16'h0100, 16'h4000, 32'hFFFF_FFFF, 32'h8000_0001, 16'h0800);
        for (int r = int'(REG_SPARE_LO); r <= int'(REG_SPARE_HI); r++)
            write_reg(3'(r), 32'hFFFF_FFFF);
        push_sample(32'd0);
        push_sample(32'd1);
        push_sample(32'h8000_0000);
        push_sample(32'hFFFF_FFFF);
        push_sample($urandom);
        push_sample($urandom);
        wait_until_idle();
    endtask

    // Register extremes back to back with both sides streaming at full rate.
    task automatic test_register_extremes();
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        for (int s = 0; s < 6; s++)
        begin
            case (s)
                0: load_setting(16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
                1: load_setting(16'h8000, 16'h8000, 32'd0, 32'h4000_0000, 16'hFFFF);
                2: load_setting(16'h0000, 16'h8000, 32'h8000_0000, 32'd1, 16'h0000);
                3: load_setting(16'h8000, 16'h7FFF, 32'd1, 32'hFFFF_FFFF, 16'h0001);
                4: load_setting(16'h7FFF, 16'h8000, $urandom, $urandom, 16'($urandom));
                default: load_setting(16'h0000, 16'h0000, $urandom, $urandom, 16'hFFFF);
            endcase
            repeat (20) push_sample(pick_sample_index());
            wait_until_idle();
        end
    endtask

    // Random settings in phases; most phases idle on both sides, some stream.
    task automatic test_random_phases();
        int unsigned phase_len;
        while (samples_sent < TOTAL_SAMPLES)
        begin
            load_setting(pick_q15(), pick_q15(), pick_step(), pick_step(), pick_mod_index());
            tx_idling = ($urandom_range(0, 4) != 0);
            rx_idling = ($urandom_range(0, 4) != 0);
            phase_len = $urandom_range(30, 90);
            repeat (phase_len) push_sample(pick_sample_index());
            wait_until_idle();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i <= LUT_LEN; i++)
            sine_lut[i] = quarter_sine(i);

        // Hold reset at the start, once, then release it.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_corners();
        test_register_extremes();
        test_random_phases();
        wait_until_idle();

        $display("Sent %0d sample indexes under %0d register settings; %0d results compared.",
                 samples_sent, settings_loaded, results_checked);
        $display("Mismatches: %0d, results still outstanding: %0d.",
                 mismatch_count, pending_samples.size());
        if (mismatch_count == 0 && pending_samples.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
src/sffm_pkg.sv
src/sffm_fifo.sv
src/sffm_front.sv
src/sffm_back.sv
src/single_frequency_fm_source_unit.sv
tb/single_frequency_fm_source_unit_test.sv
